>>> rtl/btve_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// btve_pkg: shared types and constants
// Beat payloads, command codes and fixed widths of the Bezier triangle
// vertex evaluator.
// ----------------------------------------------------------------------------
package btve_pkg;

  // Fixed field widths
  localparam int unsigned COORD_WIDTH = 16;
  localparam int unsigned SUBDIV_W    = 7;
  localparam int unsigned NUM_CORNERS = 3;

  // Subdivision count limits and reset value
  localparam logic [SUBDIV_W-1:0] MAX_SUBDIV   = 7'd64;
  localparam logic [SUBDIV_W-1:0] MIN_SUBDIV   = 7'd1;
  localparam logic [SUBDIV_W-1:0] SUBDIV_RESET = 7'd10;

  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_EVAL = 1'b1
  } action_e;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef struct packed {
    action_e             action;
    logic [1:0]          corner_sel;
    coord_t              pos_x;
    coord_t              pos_y;
    coord_t              pos_z;
    coord_t              nrm_x;
    coord_t              nrm_y;
    coord_t              nrm_z;
    logic [SUBDIV_W-1:0] row_i;
    logic [SUBDIV_W-1:0] col_j;
  } in_beat_t;

  typedef struct packed {
    coord_t             out_px;
    coord_t             out_py;
    coord_t             out_pz;
    logic signed [15:0] out_nx;
    logic signed [15:0] out_ny;
    logic signed [15:0] out_nz;
    logic               zero_normal;
    logic               outside_patch;
  } out_beat_t;

endpackage
`default_nettype wire

>>> rtl/btve_chan_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// btve_chan_if: valid/ready channel
// One beat moves at a rising edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface btve_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/bezier_triangle_vertex_evaluator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bezier_triangle_vertex_evaluator: quadratic Bezier triangle tessellator
// Corner load beats and grid point beats in, one vertex beat per grid point.
// ----------------------------------------------------------------------------
// Usage:
//   in_if  carries load beats (action ACT_LOAD, one corner position and
//          normal) and evaluate beats (action ACT_EVAL, grid point i, j).
//   out_if carries one vertex per evaluate beat, in order; loads give none.
//   cfg_we_i / cfg_wdata_i write the subdivision count n; write it only
//   while no evaluate beat is in flight.
// Timing:
//   A load takes effect at its accept edge; an evaluate beat accepted in
//   the next cycle already sees it.
//   Throughput is one beat per cycle while the receiver does not stall;
//   the pipeline has 22 stages plus an output register, set by the
//   16-step quotient and 15-step normal root chains, one bit per stage.
// Reset clears the corners to zero, n to 10 and empties the pipeline.
// When the receiver stalls, full stages hold and empty stages keep
// filling; in_if.ready drops only once every stage holds a beat.
// ----------------------------------------------------------------------------
module bezier_triangle_vertex_evaluator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [btve_pkg::SUBDIV_W-1:0] cfg_wdata_i,
  btve_chan_if.sink                     in_if,
  btve_chan_if.source                   out_if
);
  import btve_pkg::*;

  localparam int unsigned NSTG     = 22;
  localparam int unsigned DIV_LAST = 21;

  typedef struct packed {
    logic [SUBDIV_W-1:0]   i;
    logic [SUBDIV_W-1:0]   j;
    logic [SUBDIV_W-1:0]   n;
    logic [SUBDIV_W-1:0]   k;
    logic                  outside;
    logic [8:0][15:0]      pos;
    logic [8:0][15:0]      nrm;
    logic [2:0][14:0]      coef;
    logic [13:0]           den;
    logic [2:0][22:0]      nv;
    logic [2:0][31:0]      num;
    logic [2:0][21:0]      mag;
    logic [2:0]            nneg;
    logic                  nzero;
    logic [2:0]            sh;
    logic [2:0][31:0]      rem;
    logic [14:0]           dvs;
    logic [2:0][15:0]      quo;
    logic [2:0][29:0]      sq;
    logic [31:0]           ssum;
    logic [2:0][59:0]      rhs;
    logic [2:0][65:0]      acc;
    logic [2:0][65:0]      lin;
    logic [2:0][14:0]      root;
  } stage_t;

  // Work done between stage s-1 and stage s
  function automatic stage_t stage_next(input stage_t p, input int unsigned s);
    stage_t             r;
    logic [8:0]         w0;
    logic [8:0]         w1;
    logic [8:0]         w2;
    logic [15:0]        cp;
    logic signed [23:0] nsum;
    logic signed [31:0] psum;
    logic signed [22:0] nvs;
    logic [21:0]        mx;
    logic [2:0]         sh;
    logic [14:0]        m;
    logic [31:0]        dsh;
    logic signed [65:0] cand;
    logic [3:0]         b;
    r = p;
    b = 4'(DIV_LAST - s);
    // k = n - i - j
    if (s == 1) begin
      r.k = p.outside ? '0 : SUBDIV_W'(p.n - p.i - p.j);
    end
    // Per-corner weights and normal blend
    if (s == 2) begin
      w0 = {2'b0, p.i} * 9'd3 + {p.j, 2'b0} + {1'b0, p.k, 1'b0};
      w1 = {2'b0, p.j} * 9'd3 + {1'b0, p.i, 1'b0} + {p.k, 2'b0};
      w2 = {2'b0, p.k} * 9'd3 + {1'b0, p.j, 1'b0} + {p.i, 2'b0};
      cp = {9'b0, p.i} * {7'b0, w0};
      r.coef[0] = cp[14:0];
      cp = {9'b0, p.j} * {7'b0, w1};
      r.coef[1] = cp[14:0];
      cp = {9'b0, p.k} * {7'b0, w2};
      r.coef[2] = cp[14:0];
      r.den = 14'({7'b0, p.n} * {7'b0, p.n} * 14'd3);
      for (int a = 0; a < 3; a++) begin
        nsum = $signed({1'b0, p.i}) * $signed(p.nrm[a])
             + $signed({1'b0, p.j}) * $signed(p.nrm[3 + a])
             + $signed({1'b0, p.k}) * $signed(p.nrm[6 + a]);
        r.nv[a] = nsum[22:0];
      end
    end
    // Position numerator and normal magnitudes
    if (s == 3) begin
      for (int a = 0; a < 3; a++) begin
        psum = $signed({1'b0, p.coef[0]}) * $signed(p.pos[a])
             + $signed({1'b0, p.coef[1]}) * $signed(p.pos[3 + a])
             + $signed({1'b0, p.coef[2]}) * $signed(p.pos[6 + a]);
        r.num[a] = psum;
        nvs = $signed(p.nv[a]);
        r.nneg[a] = nvs[22];
        r.mag[a] = nvs[22] ? 22'(-nvs) : 22'(nvs);
      end
    end
    // Biased dividend, divisor and normal shift
    if (s == 4) begin
      for (int a = 0; a < 3; a++) begin
        r.rem[a] = {p.num[a][30:0], 1'b0} + {2'b0, p.den, 16'b0} + {18'b0, p.den};
        r.quo[a] = '0;
      end
      r.dvs = {p.den, 1'b0};
      mx = p.mag[0];
      if (p.mag[1] > mx) mx = p.mag[1];
      if (p.mag[2] > mx) mx = p.mag[2];
      r.nzero = (mx != '0);
      sh = 3'd7;
      for (int t = 7; t >= 0; t--) begin
        if ((mx >> t) <= 22'd32767) sh = 3'(t);
      end
      r.sh = sh;
    end
    // Scaled magnitudes squared
    if (s == 5) begin
      for (int a = 0; a < 3; a++) begin
        m = 15'(p.mag[a] >> p.sh);
        r.sq[a] = {15'b0, m} * {15'b0, m};
      end
    end
    // Root search setup: start at q = 0, t = -1
    if (s == 6) begin
      r.ssum = {2'b0, p.sq[0]} + {2'b0, p.sq[1]} + {2'b0, p.sq[2]};
      for (int a = 0; a < 3; a++) begin
        r.rhs[a]  = {p.sq[a], 30'b0};
        r.acc[a]  = {34'b0, r.ssum};
        r.lin[a]  = -{34'b0, r.ssum};
        r.root[a] = '0;
      end
    end
    // One quotient bit per stage
    if (s >= 6 && s <= DIV_LAST) begin
      dsh = {17'b0, p.dvs} << b;
      for (int a = 0; a < 3; a++) begin
        if (r.rem[a] >= dsh) begin
          r.rem[a]    = r.rem[a] - dsh;
          r.quo[a][b] = 1'b1;
        end
      end
    end
    // One root bit per stage: keep bit if (2q-1)^2 * s <= c^2 * 2^30
    if (s >= 7 && s <= DIV_LAST) begin
      for (int a = 0; a < 3; a++) begin
        cand = $signed(p.acc[a]) + ($signed(p.lin[a]) <<< (b + 5'd2))
             + $signed({34'b0, p.ssum} << (2 * b + 2));
        if (cand <= $signed({6'b0, p.rhs[a]})) begin
          r.acc[a]     = cand;
          r.lin[a]     = 66'($signed(p.lin[a]) + $signed({34'b0, p.ssum} << (b + 4'd1)));
          r.root[a][b] = 1'b1;
        end
      end
    end
    return r;
  endfunction

  logic [SUBDIV_W-1:0] subdiv_q;
  logic [8:0][15:0]    pos_q;
  logic [8:0][15:0]    nrm_q;
  stage_t              st_q [NSTG];
  stage_t              st_d [NSTG];
  logic [NSTG-1:0]     vld_q;
  logic [NSTG-1:0]     rdy;
  out_beat_t           out_q;
  out_beat_t           out_d;
  logic                out_vld_q;
  logic                out_rdy;
  logic                in_acc;
  logic [SUBDIV_W-1:0] n_eff;
  logic [3:0]          cidx;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      subdiv_q <= SUBDIV_RESET;
    end else if (cfg_we_i) begin
      subdiv_q <= cfg_wdata_i;
    end
  end

  // Handshake: a stage takes a beat when empty or when it moves on
  assign out_rdy         = !out_vld_q || out_if.ready;
  assign rdy[NSTG-1]     = !vld_q[NSTG-1] || out_rdy;
  for (genvar s = 0; s < NSTG - 1; s++) begin : g_rdy
    assign rdy[s] = !vld_q[s] || rdy[s + 1];
  end
  assign in_if.ready = rdy[0];
  assign in_acc      = in_if.valid && rdy[0];

  // Corner store
  assign cidx = 4'(in_if.data.corner_sel) * 4'd3;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      nrm_q <= '0;
    end else if (in_acc && in_if.data.action == ACT_LOAD
                 && in_if.data.corner_sel < 2'(NUM_CORNERS)) begin
      pos_q[cidx]        <= in_if.data.pos_x;
      pos_q[cidx + 4'd1] <= in_if.data.pos_y;
      pos_q[cidx + 4'd2] <= in_if.data.pos_z;
      nrm_q[cidx]        <= in_if.data.nrm_x;
      nrm_q[cidx + 4'd1] <= in_if.data.nrm_y;
      nrm_q[cidx + 4'd2] <= in_if.data.nrm_z;
    end
  end

  // Entry stage: clamp n, flag points outside the patch, snapshot corners
  always_comb begin
    if (subdiv_q < MIN_SUBDIV) begin
      n_eff = MIN_SUBDIV;
    end else if (subdiv_q > MAX_SUBDIV) begin
      n_eff = MAX_SUBDIV;
    end else begin
      n_eff = subdiv_q;
    end
    st_d[0]         = '0;
    st_d[0].i       = in_if.data.row_i;
    st_d[0].j       = in_if.data.col_j;
    st_d[0].n       = n_eff;
    st_d[0].outside = ({1'b0, in_if.data.row_i} + {1'b0, in_if.data.col_j})
                      > {1'b0, n_eff};
    st_d[0].pos     = pos_q;
    st_d[0].nrm     = nrm_q;
  end

  for (genvar s = 1; s < NSTG; s++) begin : g_next
    assign st_d[s] = stage_next(st_q[s - 1], s);
  end

  // Pipeline valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) vld_q[0] <= in_if.valid && in_if.data.action == ACT_EVAL;
      for (int s = 1; s < NSTG; s++) begin
        if (rdy[s]) vld_q[s] <= vld_q[s - 1];
      end
    end
  end

  // Pipeline payload
  for (genvar s = 0; s < NSTG; s++) begin : g_stage
    always_ff @(posedge clk_i) begin
      if (rdy[s]) begin
        st_q[s] <= st_d[s];
      end
    end
  end

  // Output formatting
  always_comb begin
    stage_t p;
    p     = st_q[NSTG-1];
    out_d = '0;
    out_d.outside_patch = p.outside;
    if (!p.outside) begin
      out_d.out_px      = {~p.quo[0][15], p.quo[0][14:0]};
      out_d.out_py      = {~p.quo[1][15], p.quo[1][14:0]};
      out_d.out_pz      = {~p.quo[2][15], p.quo[2][14:0]};
      out_d.zero_normal = !p.nzero;
      if (p.nzero) begin
        out_d.out_nx = p.nneg[0] ? 16'(-{1'b0, p.root[0]}) : {1'b0, p.root[0]};
        out_d.out_ny = p.nneg[1] ? 16'(-{1'b0, p.root[1]}) : {1'b0, p.root[1]};
        out_d.out_nz = p.nneg[2] ? 16'(-{1'b0, p.root[2]}) : {1'b0, p.root[2]};
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_rdy) begin
      out_vld_q <= vld_q[NSTG-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_rdy) begin
      out_q <= out_d;
    end
  end

  assign out_if.valid = out_vld_q;
  assign out_if.data  = out_q;

  // Checks
  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> !(out_if.data.zero_normal && out_if.data.outside_patch))
    else $error("zero_normal and outside_patch both set");

  a_zero_nrm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && out_if.data.zero_normal) |->
      (out_if.data.out_nx == 16'sd0 && out_if.data.out_ny == 16'sd0
       && out_if.data.out_nz == 16'sd0))
    else $error("zero normal beat carries a nonzero normal");

  a_nrm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> (out_if.data.out_nx <= 16'sd16384 && out_if.data.out_nx >= -16'sd16384))
    else $error("normal x outside unit range");

  a_load_no_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_if.valid && in_if.ready && in_if.data.action == ACT_LOAD) |=> !vld_q[0])
    else $error("load beat entered the pipeline");

endmodule
`default_nettype wire
